FILE: hw/rtl/ordered_insert_draw_list_top_macros.svh
// Assertion macros for the draw list RTL.
// Used by modules that include this header; no other dependencies.
`ifndef ORDERED_INSERT_DRAW_LIST_TOP_MACROS_SVH
`define ORDERED_INSERT_DRAW_LIST_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define OIDL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("oidl assertion failed");
`define OIDL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("oidl assertion failed");
`else
`define OIDL_ASSERT_NOW(lbl, ante, cons)
`define OIDL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/oidl_pkg.sv
// Types, codes and sizes of the ordered draw list.
// No dependencies; imported by oidl_ctrl, the top level and the testbench.
package oidl_pkg;

  localparam int Depth   = 32;
  localparam int IdxW    = $clog2(Depth);
  localparam int HandleW = 16;
  localparam int KeyW    = 8;
  localparam int DispW   = 3;
  localparam int CamW    = 2;
  localparam int PosW    = 6;
  localparam int StatusW = 3;

  typedef enum logic [1:0] {
    ModeAdd   = 2'd0,
    ModeClear = 2'd1,
    ModeDrain = 2'd2
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    StatAdded   = 3'd0,
    StatFull    = 3'd1,
    StatCleared = 3'd2,
    StatEmitted = 3'd3,
    StatEmpty   = 3'd4
  } status_e;

  typedef struct packed {
    logic [KeyW-1:0]    key;
    logic [HandleW-1:0] handle;
    logic [DispW-1:0]   disp;
    logic [CamW-1:0]    cam;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef struct packed {
    logic            strobe;
    status_e         status;
    entry_t          entry;
    logic [PosW-1:0] position;
    logic            last;
  } result_t;

endpackage

FILE: hw/rtl/oidl_ram.sv
// Simple dual-port entry RAM: one write port, one read port, registered read.
// No dependencies.
module oidl_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: hw/rtl/oidl_ctrl.sv
// Sequencer of the draw list: insertion scan, drain walk, count and result beat.
// Depends on oidl_pkg and the assertion macro header.
`include "ordered_insert_draw_list_top_macros.svh"

module oidl_ctrl import oidl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        mode_i,
  input  entry_t            new_i,
  output logic              we_o,
  output logic [IdxW-1:0]   waddr_o,
  output entry_t            wdata_o,
  output logic [IdxW-1:0]   raddr_o,
  input  entry_t            rdata_i,
  output result_t           res_o
);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StScan  = 4'b0010,
    StPut   = 4'b0100,
    StDrain = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  entry_t          new_q, new_d;
  result_t         res_q, res_d;

  assign busy  = (state_q != StIdle);
  assign res_o = res_q;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    new_d   = new_q;
    raddr_o = '0;
    we_o    = 1'b0;
    waddr_o = '0;
    wdata_o = new_q;
    res_d   = '0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          unique case (mode_i)
            ModeAdd: begin
              res_d.last = 1'b1;
              if (cnt_q >= IdxW'(Depth - 1)) begin
                res_d.strobe = 1'b1;
                res_d.status = StatFull;
              end else begin
                new_d = new_i;
                if (cnt_q == '0) begin
                  state_d = StPut;
                end else begin
                  raddr_o = cnt_q - IdxW'(1);
                  idx_d   = cnt_q - IdxW'(1);
                  state_d = StScan;
                end
              end
            end
            ModeClear: begin
              cnt_d        = '0;
              res_d.strobe = 1'b1;
              res_d.status = StatCleared;
              res_d.last   = 1'b1;
            end
            ModeDrain: begin
              if (cnt_q == '0) begin
                res_d.strobe = 1'b1;
                res_d.status = StatEmpty;
                res_d.last   = 1'b1;
              end else begin
                raddr_o = '0;
                idx_d   = '0;
                state_d = StDrain;
              end
            end
            default: ;
          endcase
        end
      end
      StScan: begin
        we_o    = 1'b1;
        waddr_o = idx_q + IdxW'(1);
        if (rdata_i.key > new_q.key) begin
          wdata_o = rdata_i;
          if (idx_q == '0) begin
            state_d = StPut;
          end else begin
            raddr_o = idx_q - IdxW'(1);
            idx_d   = idx_q - IdxW'(1);
          end
        end else begin
          wdata_o        = new_q;
          cnt_d          = cnt_q + IdxW'(1);
          res_d.strobe   = 1'b1;
          res_d.status   = StatAdded;
          res_d.position = PosW'(idx_q + IdxW'(1));
          res_d.last     = 1'b1;
          state_d        = StIdle;
        end
      end
      StPut: begin
        we_o         = 1'b1;
        waddr_o      = '0;
        wdata_o      = new_q;
        cnt_d        = cnt_q + IdxW'(1);
        res_d.strobe = 1'b1;
        res_d.status = StatAdded;
        res_d.last   = 1'b1;
        state_d      = StIdle;
      end
      StDrain: begin
        res_d.strobe   = 1'b1;
        res_d.status   = StatEmitted;
        res_d.entry    = rdata_i;
        res_d.position = PosW'(idx_q);
        if (idx_q == cnt_q - IdxW'(1)) begin
          res_d.last = 1'b1;
          state_d    = StIdle;
        end else begin
          raddr_o = idx_q + IdxW'(1);
          idx_d   = idx_q + IdxW'(1);
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    new_q <= new_d;
  end

  `OIDL_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= IdxW'(Depth - 1))
  `OIDL_ASSERT_NOW(a_write_busy, we_o, state_q != StIdle)
  `OIDL_ASSERT_NOW(a_last_idle, res_q.strobe && res_q.last, state_q == StIdle)
  `OIDL_ASSERT_NEXT(a_clear_beat, start && !busy && mode_i == ModeClear,
                    res_q.strobe && res_q.status == StatCleared && cnt_q == '0)

endmodule

FILE: hw/rtl/ordered_insert_draw_list_top.sv
// Ordered draw list: an add scans and shifts one entry per cycle through the read port and
// the write port of the entry RAM, walking down from the top slot until the insertion point;
// a drain gives one result beat per cycle; clear, full rejection and an empty drain answer
// with a single result beat. busy is high while an add (scan or put) or a drain runs;
// result beats are presented for one cycle on strobe_o and cannot be held off by the
// receiver.
// Depends on oidl_pkg, oidl_ram and oidl_ctrl.
module ordered_insert_draw_list_top import oidl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           mode_i,
  input  logic [KeyW-1:0]      order_key_i,
  input  logic [HandleW-1:0]   item_handle_i,
  input  logic [DispW-1:0]     display_kind_i,
  input  logic [CamW-1:0]      camera_kind_i,
  output logic                 strobe_o,
  output logic [StatusW-1:0]   status_o,
  output logic [HandleW-1:0]   out_handle_o,
  output logic [DispW-1:0]     out_display_o,
  output logic [CamW-1:0]      out_camera_o,
  output logic [KeyW-1:0]      out_order_o,
  output logic [PosW-1:0]      out_position_o,
  output logic                 last_o
);

  entry_t          new_entry;
  entry_t          wdata;
  entry_t          rdata;
  logic [EntryW-1:0] rdata_raw;
  logic            we;
  logic [IdxW-1:0] waddr;
  logic [IdxW-1:0] raddr;
  result_t         res;

  assign new_entry.key    = order_key_i;
  assign new_entry.handle = item_handle_i;
  assign new_entry.disp   = display_kind_i;
  assign new_entry.cam    = camera_kind_i;
  assign rdata            = entry_t'(rdata_raw);

  oidl_ram #(
    .Width(EntryW),
    .Depth(Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  oidl_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .mode_i  (mode_i),
    .new_i   (new_entry),
    .we_o    (we),
    .waddr_o (waddr),
    .wdata_o (wdata),
    .raddr_o (raddr),
    .rdata_i (rdata),
    .res_o   (res)
  );

  assign strobe_o       = res.strobe;
  assign status_o       = res.status;
  assign out_handle_o   = res.entry.handle;
  assign out_display_o  = res.entry.disp;
  assign out_camera_o   = res.entry.cam;
  assign out_order_o    = res.entry.key;
  assign out_position_o = res.position;
  assign last_o         = res.last;

endmodule

FILE: tb/sv/tb_ordered_insert_draw_list_top.sv
// Self-checking testbench for ordered_insert_draw_list_top: a command queue drives
// directed and random add, clear, drain and ignored-mode beats and checks every result beat.
// Depends on oidl_pkg and the ordered_insert_draw_list_top RTL only.
module tb_ordered_insert_draw_list_top;
  timeunit 1ns;
  timeprecision 1ps;
  import oidl_pkg::*;

  localparam logic [1:0] ModeIgnored = 2'd3;
  localparam int SettleCycles = 80;

  typedef struct {
    logic [1:0]         mode;
    logic [KeyW-1:0]    key;
    logic [HandleW-1:0] handle;
    logic [DispW-1:0]   disp;
    logic [CamW-1:0]    cam;
    int                 gap;
    bit                 hold;
  } cmd_t;

  typedef struct packed {
    status_e         status;
    entry_t          entry;
    logic [PosW-1:0] pos;
    logic            last;
  } draw_beat_t;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         mode_i = '0;
  logic [KeyW-1:0]    order_key_i = '0;
  logic [HandleW-1:0] item_handle_i = '0;
  logic [DispW-1:0]   display_kind_i = '0;
  logic [CamW-1:0]    camera_kind_i = '0;
  logic               strobe_o;
  logic [StatusW-1:0] status_o;
  logic [HandleW-1:0] out_handle_o;
  logic [DispW-1:0]   out_display_o;
  logic [CamW-1:0]    out_camera_o;
  logic [KeyW-1:0]    out_order_o;
  logic [PosW-1:0]    out_position_o;
  logic               last_o;

  cmd_t       cmd_q[$];
  draw_beat_t due_beats_q[$];
  entry_t     list_mem[Depth];
  int         list_cnt = 0;
  int         cmd_total = 0;
  int         cmds_taken = 0;
  int         err_cnt = 0;
  logic       took = 1'b0;
  cmd_t       cur_cmd;
  bit         cur_valid = 1'b0;
  int         gap_left = 0;

  ordered_insert_draw_list_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .order_key_i    (order_key_i),
    .item_handle_i  (item_handle_i),
    .display_kind_i (display_kind_i),
    .camera_kind_i  (camera_kind_i),
    .strobe_o       (strobe_o),
    .status_o       (status_o),
    .out_handle_o   (out_handle_o),
    .out_display_o  (out_display_o),
    .out_camera_o   (out_camera_o),
    .out_order_o    (out_order_o),
    .out_position_o (out_position_o),
    .last_o         (last_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function void predict_draw_beats(input logic [1:0] mode, input logic [KeyW-1:0] key,
                                   input logic [HandleW-1:0] handle,
                                   input logic [DispW-1:0] disp, input logic [CamW-1:0] cam);
    draw_beat_t b;
    int         slot;
    b = '0;
    b.last = 1'b1;
    case (mode)
      ModeAdd: begin
        if (list_cnt >= Depth - 1) begin
          b.status = StatFull;
        end else begin
          slot = list_cnt;
          for (int i = 0; i < list_cnt; i++) begin
            if (list_mem[i].key > key) begin
              slot = i;
              break;
            end
          end
          for (int i = list_cnt; i > slot; i--) list_mem[i] = list_mem[i-1];
          list_mem[slot] = '{key: key, handle: handle, disp: disp, cam: cam};
          list_cnt++;
          b.status = StatAdded;
          b.pos = PosW'(slot);
        end
        due_beats_q.push_back(b);
      end
      ModeClear: begin
        list_cnt = 0;
        b.status = StatCleared;
        due_beats_q.push_back(b);
      end
      ModeDrain: begin
        if (list_cnt == 0) begin
          b.status = StatEmpty;
          due_beats_q.push_back(b);
        end else begin
          for (int i = 0; i < list_cnt; i++) begin
            b.status = StatEmitted;
            b.entry = list_mem[i];
            b.pos = PosW'(i);
            b.last = (i == list_cnt - 1);
            due_beats_q.push_back(b);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function void push_cmd(input logic [1:0] mode, input logic [KeyW-1:0] key,
                         input logic [HandleW-1:0] handle, input logic [DispW-1:0] disp,
                         input logic [CamW-1:0] cam, input int gap, input bit hold);
    cmd_t c;
    c = '{mode: mode, key: key, handle: handle, disp: disp, cam: cam, gap: gap, hold: hold};
    cmd_q.push_back(c);
  endfunction

  function int rand_gap(input bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function void push_rand(input logic [1:0] mode, input bit burst);
    logic [KeyW-1:0] key;
    key = $urandom_range(0, 1) ? KeyW'($urandom_range(0, 3)) : KeyW'($urandom_range(0, 255));
    push_cmd(mode, key, HandleW'($urandom_range(0, 65535)), DispW'($urandom_range(0, 7)),
             CamW'($urandom_range(0, 3)), rand_gap(burst), $urandom_range(0, 19) == 0);
  endfunction

  // feed one command beat per handshake
  always @(negedge clk_i) begin : drive_proc
    logic go;
    go = 1'b0;
    if (rst_ni) begin
      if (start && !took) begin
        go = 1'b1;
      end else begin
        if (!cur_valid && cmd_q.size() != 0) begin
          cur_cmd = cmd_q.pop_front();
          cur_valid = 1'b1;
          gap_left = cur_cmd.gap;
        end
        if (cur_valid) begin
          if (gap_left > 0) begin
            gap_left--;
          end else if (!cur_cmd.hold || due_beats_q.size() == 0) begin
            mode_i <= cur_cmd.mode;
            order_key_i <= cur_cmd.key;
            item_handle_i <= cur_cmd.handle;
            display_kind_i <= cur_cmd.disp;
            camera_kind_i <= cur_cmd.cam;
            go = 1'b1;
            cur_valid = 1'b0;
          end
        end
      end
    end
    start <= go;
  end

  always @(posedge clk_i) begin : watch_proc
    draw_beat_t e;
    took <= rst_ni && start && !busy;
    if (rst_ni) begin
      if (start && !busy) begin
        predict_draw_beats(mode_i, order_key_i, item_handle_i, display_kind_i, camera_kind_i);
        cmds_taken++;
      end
      if (strobe_o) begin
        if (due_beats_q.size() == 0) begin
          $error("unexpected result beat: status %0d", status_o);
          err_cnt++;
        end else begin
          e = due_beats_q.pop_front();
          if (status_o !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status_o);
            err_cnt++;
          end
          if (out_handle_o !== e.entry.handle) begin
            $error("out_handle: expected %0h, got %0h", e.entry.handle, out_handle_o);
            err_cnt++;
          end
          if (out_display_o !== e.entry.disp) begin
            $error("out_display: expected %0d, got %0d", e.entry.disp, out_display_o);
            err_cnt++;
          end
          if (out_camera_o !== e.entry.cam) begin
            $error("out_camera: expected %0d, got %0d", e.entry.cam, out_camera_o);
            err_cnt++;
          end
          if (out_order_o !== e.entry.key) begin
            $error("out_order: expected %0d, got %0d", e.entry.key, out_order_o);
            err_cnt++;
          end
          if (out_position_o !== e.pos) begin
            $error("out_position: expected %0d, got %0d", e.pos, out_position_o);
            err_cnt++;
          end
          if (last_o !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, last_o);
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin : stim_proc
    int  rand_cnt;
    int  k;
    bit  burst;
    push_cmd(ModeDrain, 8'd0, 16'h0000, 3'd0, 2'd0, 0, 1'b0);
    push_cmd(ModeAdd, 8'd128, 16'h0000, 3'd0, 2'd0, 0, 1'b0);
    push_cmd(ModeAdd, 8'd128, 16'hFFFF, 3'd7, 2'd3, 0, 1'b0);
    push_cmd(ModeAdd, 8'd0, 16'h1234, 3'd5, 2'd1, 2, 1'b0);
    push_cmd(ModeAdd, 8'd255, 16'hA5A5, 3'd2, 2'd2, 0, 1'b0);
    push_cmd(ModeAdd, 8'd128, 16'h5A5A, 3'd3, 2'd1, 0, 1'b0);
    push_cmd(ModeIgnored, 8'hFF, 16'hFFFF, 3'd7, 2'd3, 0, 1'b0);
    push_cmd(ModeDrain, 8'hFF, 16'hFFFF, 3'd7, 2'd3, 0, 1'b0);
    push_cmd(ModeClear, 8'd0, 16'h0000, 3'd0, 2'd0, 0, 1'b1);
    push_cmd(ModeDrain, 8'd0, 16'h0000, 3'd0, 2'd0, 0, 1'b0);
    push_cmd(ModeAdd, 8'd255, 16'h8001, 3'd4, 2'd2, 0, 1'b0);
    push_cmd(ModeAdd, 8'd0, 16'h7FFE, 3'd3, 2'd1, 0, 1'b0);
    push_cmd(ModeDrain, 8'd0, 16'h0000, 3'd0, 2'd0, 5, 1'b0);
    push_cmd(ModeIgnored, 8'd0, 16'h0000, 3'd0, 2'd0, 0, 1'b0);
    push_cmd(ModeClear, 8'd0, 16'h0000, 3'd0, 2'd0, 0, 1'b0);

    // fill past capacity to hit the full rejection, then drain the whole list
    for (int i = 0; i < Depth + 1; i++) push_rand(ModeAdd, i < 16);
    push_rand(ModeDrain, 1'b0);
    push_rand(ModeClear, 1'b0);
    rand_cnt = Depth + 3;

    while (rand_cnt < 260) begin
      if ($urandom_range(0, 9) < 8) begin
        burst = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 2) == 0) begin
          push_rand(ModeClear, burst);
          rand_cnt++;
        end
        k = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 34) : $urandom_range(1, 6);
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(0, 15) == 0) push_rand(ModeIgnored, burst);
          push_rand(ModeAdd, burst);
        end
        push_rand(ModeDrain, burst);
        rand_cnt += k + 1;
      end else begin
        k = $urandom_range(0, 3);
        push_rand(k[1:0], 1'b0);
        if (k != ModeIgnored) rand_cnt++;
      end
    end
    cmd_total = cmd_q.size();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (cmds_taken != cmd_total || due_beats_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (err_cnt == 0 && due_beats_q.size() == 0) begin
      $display("tb_ordered_insert_draw_list_top passed");
    end else begin
      $display("tb_ordered_insert_draw_list_top failed");
    end
    $finish;
  end

  initial begin : watchdog_proc
    #2_000_000;
    $display("tb_ordered_insert_draw_list_top failed");
    $finish;
  end

endmodule
